@@ rtl/c8ie_pkg.sv @@
package c8ie_pkg;

    localparam int MEM_BYTES    = 4096;
    localparam int STACK_DEPTH  = 16;
    localparam int LOAD_ADDRESS = 512;
    localparam int GLYPH_HEIGHT = 5;

    localparam int MEM_AW = $clog2(MEM_BYTES);
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int SP_IW  = $clog2(STACK_DEPTH);
    localparam int GLYPH_BYTES = 80;

    typedef enum logic [1:0] {
        FN_EXEC  = 2'd0,
        FN_WRITE = 2'd1,
        FN_READ  = 2'd2,
        FN_START = 2'd3
    } t_func;

    // opcode high nibbles
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEK  = 4'h3;
    localparam logic [3:0] OP_SNEK = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LDK  = 4'h6;
    localparam logic [3:0] OP_ADDK = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_MISC = 4'hF;
    localparam logic [15:0] OP_RET = 16'h00EE;

    // 8xy_ sub-codes
    localparam logic [3:0] SUB_LD   = 4'h0;
    localparam logic [3:0] SUB_OR   = 4'h1;
    localparam logic [3:0] SUB_AND  = 4'h2;
    localparam logic [3:0] SUB_XOR  = 4'h3;
    localparam logic [3:0] SUB_ADD  = 4'h4;
    localparam logic [3:0] SUB_SUB  = 4'h5;
    localparam logic [3:0] SUB_SHR  = 4'h6;
    localparam logic [3:0] SUB_SUBN = 4'h7;
    localparam logic [3:0] SUB_SHL  = 4'hE;

    // Fx__ sub-codes
    localparam logic [7:0] FX_DT_RD = 8'h07;
    localparam logic [7:0] FX_DT_WR = 8'h15;
    localparam logic [7:0] FX_ST_WR = 8'h18;
    localparam logic [7:0] FX_ADDI  = 8'h1E;
    localparam logic [7:0] FX_GLYPH = 8'h29;
    localparam logic [7:0] FX_BCD   = 8'h33;
    localparam logic [7:0] FX_STORE = 8'h55;
    localparam logic [7:0] FX_LOAD  = 8'h65;

    typedef enum logic [3:0] {
        ALU_PASS,
        ALU_OR,
        ALU_AND,
        ALU_XOR,
        ALU_ADD8,
        ALU_SUB8,
        ALU_SUBN8,
        ALU_SHR,
        ALU_SHL,
        ALU_EQ,
        ALU_ADD12,
        ALU_ADD16,
        ALU_MUL,
        ALU_DIG_H,
        ALU_DIG_T,
        ALU_DIG_O
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [15:0] a;
        logic [15:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [15:0] res;
        logic        flag;
    } t_alu_rsp;

    localparam logic [7:0] GLYPHS [GLYPH_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // reset image of the byte memory
    function automatic logic [7:0] glyph_byte(input logic [MEM_AW-1:0] a);
        logic [7:0] v;
        v = 8'h00;
        if (int'(a) < GLYPH_BYTES) begin
            v = GLYPHS[a[6:0]];
        end
        return v;
    endfunction

    // 12-bit address folded into the memory size (a < 8 * MEM_BYTES)
    function automatic logic [MEM_AW-1:0] mem_index(input logic [11:0] a);
        int v;
        v = int'(a);
        if (v >= 4 * MEM_BYTES) v = v - 4 * MEM_BYTES;
        if (v >= 2 * MEM_BYTES) v = v - 2 * MEM_BYTES;
        if (v >= MEM_BYTES)     v = v - MEM_BYTES;
        return MEM_AW'(v);
    endfunction

endpackage

@@ rtl/chip8_instruction_execute_top.sv @@
// CHIP-8 execute unit.
// Input channel (i_valid / o_ready): one transfer carries a function code, an
// instruction word, a random byte and a memory address/data pair. Function 0
// executes the word, 1 writes a memory byte, 2 reads one, 3 starts the program.
// Output channel (o_valid / i_ready): one result transfer per input transfer
// with PC, I, Vx, VF, both timers, the read byte and the stack fault bit.
// Each item steps through the sequencer states; memory reads, ops that read
// registers, ops that skip or set VF, BCD and Fx55/Fx65 (x+1 bytes) take more
// of them; register and memory bytes pass through the registered-read register
// file and byte memory, and all arithmetic goes through the shared ALU.
// One item is in flight; o_ready is high only in idle. A finished result sits
// in the output register, so the next item is taken while it waits; if the
// receiver stalls longer, the sequencer holds its result in its last step.
// After reset the byte memory is swept once (one byte per cycle) to load the
// font glyphs and zeros; o_ready stays low until then.
module chip8_instruction_execute_top
    import c8ie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_opcode,
    input  logic [7:0]  i_random_byte,
    input  logic [11:0] i_mem_addr,
    input  logic [7:0]  i_mem_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_prog_counter,
    output logic [15:0] o_index_value,
    output logic [7:0]  o_dest_value,
    output logic [7:0]  o_flag_value,
    output logic [7:0]  o_delay_value,
    output logic [7:0]  o_sound_value,
    output logic [7:0]  o_read_data,
    output logic        o_stack_fault
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_MRD, S_RDB, S_EXEC, S_SKIP, S_WRF,
        S_BCD_D, S_BCD_W, S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR, S_RDX, S_RDF,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    // latched item
    t_func       r_func, n_func;
    logic [15:0] r_op, n_op;
    logic [7:0]  r_rnd, n_rnd;
    logic [11:0] r_addr, n_addr;
    logic [7:0]  r_data, n_data;

    // architectural state
    logic [11:0]     r_pc, n_pc;
    logic [15:0]     r_idx, n_idx;
    logic [7:0]      r_delay, n_delay;
    logic [7:0]      r_sound, n_sound;
    logic [11:0]     r_stack [STACK_DEPTH];
    logic [SP_W-1:0] r_sp, n_sp;
    logic [15:0]     r_gp_valid;
    logic            r_gp_rv;

    // sequencer working registers
    logic [MEM_AW-1:0] r_clr, n_clr;
    logic [3:0]  r_cnt, n_cnt;
    logic [7:0]  r_a, n_a;
    logic [7:0]  r_tmp, n_tmp;
    logic        r_flag, n_flag;
    logic        r_fault, n_fault;
    logic [7:0]  r_rd, n_rd;
    logic [7:0]  r_dest, n_dest;

    // output register
    logic        r_o_valid, n_o_valid;
    logic [11:0] r_o_pc, n_o_pc;
    logic [15:0] r_o_idx, n_o_idx;
    logic [7:0]  r_o_dest, n_o_dest;
    logic [7:0]  r_o_flag, n_o_flag;
    logic [7:0]  r_o_delay, n_o_delay;
    logic [7:0]  r_o_sound, n_o_sound;
    logic [7:0]  r_o_rd, n_o_rd;
    logic        r_o_fault, n_o_fault;

    // register file and byte memory ports
    logic        gp_we;
    logic [3:0]  gp_waddr, gp_raddr;
    logic [7:0]  gp_wdata, gp_rdata, gp_rval;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata, mem_rdata;
    logic              stack_we;
    logic [SP_W-1:0]   sp_m1;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    logic [3:0]  op_x, op_y, op_hi, op_sub;
    logic [7:0]  op_kk;
    logic [11:0] op_nnn;

    assign op_hi  = r_op[15:12];
    assign op_x   = r_op[11:8];
    assign op_y   = r_op[7:4];
    assign op_sub = r_op[3:0];
    assign op_kk  = r_op[7:0];
    assign op_nnn = r_op[11:0];
    assign sp_m1  = r_sp - 1'b1;

    // registers never written since reset read as zero
    assign gp_rval = r_gp_rv ? gp_rdata : 8'h00;

    c8ie_ram #(.WIDTH(8), .DEPTH(16)) u_gp_ram (
        .i_clk   (i_clk),
        .i_we    (gp_we),
        .i_waddr (gp_waddr),
        .i_wdata (gp_wdata),
        .i_raddr (gp_raddr),
        .o_rdata (gp_rdata)
    );

    c8ie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    c8ie_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        n_op    = r_op;
        n_rnd   = r_rnd;
        n_addr  = r_addr;
        n_data  = r_data;
        n_pc    = r_pc;
        n_idx   = r_idx;
        n_delay = r_delay;
        n_sound = r_sound;
        n_sp    = r_sp;
        n_clr   = r_clr;
        n_cnt   = r_cnt;
        n_a     = r_a;
        n_tmp   = r_tmp;
        n_flag  = r_flag;
        n_fault = r_fault;
        n_rd    = r_rd;
        n_dest  = r_dest;

        n_o_valid = r_o_valid;
        n_o_pc    = r_o_pc;
        n_o_idx   = r_o_idx;
        n_o_dest  = r_o_dest;
        n_o_flag  = r_o_flag;
        n_o_delay = r_o_delay;
        n_o_sound = r_o_sound;
        n_o_rd    = r_o_rd;
        n_o_fault = r_o_fault;
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        gp_we     = 1'b0;
        gp_waddr  = op_x;
        gp_wdata  = 8'h00;
        gp_raddr  = op_x;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = 8'h00;
        mem_raddr = '0;
        stack_we  = 1'b0;
        alu_req.op = ALU_PASS;
        alu_req.a  = 16'h0000;
        alu_req.b  = 16'h0000;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = glyph_byte(r_clr);
                if (r_clr == MEM_AW'(MEM_BYTES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end

            S_IDLE: begin
                if (i_valid) begin
                    n_func  = t_func'(i_func);
                    n_op    = i_opcode;
                    n_rnd   = i_random_byte;
                    n_addr  = i_mem_addr;
                    n_data  = i_mem_data;
                    n_fault = 1'b0;
                    n_rd    = 8'h00;
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                n_state = S_RDX;
                case (r_func)
                    FN_WRITE: begin
                        mem_we    = 1'b1;
                        mem_waddr = mem_index(r_addr);
                        mem_wdata = r_data;
                    end
                    FN_READ: begin
                        mem_raddr = mem_index(r_addr);
                        n_state   = S_MRD;
                    end
                    FN_START: n_pc = 12'(LOAD_ADDRESS);
                    FN_EXEC: begin
                        if (r_op == OP_RET) begin
                            if (r_sp == '0) begin
                                n_fault = 1'b1;
                            end else begin
                                n_sp = sp_m1;
                                n_pc = r_stack[sp_m1[SP_IW-1:0]];
                            end
                        end else begin
                            case (op_hi)
                                OP_JP: n_pc = op_nnn;
                                OP_CALL: begin
                                    if (r_sp >= SP_W'(STACK_DEPTH)) begin
                                        n_fault = 1'b1;
                                    end else begin
                                        stack_we = 1'b1;
                                        n_sp     = r_sp + 1'b1;
                                        n_pc     = op_nnn;
                                    end
                                end
                                OP_SEK, OP_SNEK, OP_SER, OP_ADDK, OP_ALU, OP_SNER: begin
                                    n_state = S_RDB;
                                end
                                OP_LDK: begin
                                    gp_we    = 1'b1;
                                    gp_wdata = op_kk;
                                end
                                OP_LDI: n_idx = {4'h0, op_nnn};
                                OP_JPV0: begin
                                    gp_raddr = 4'h0;
                                    n_state  = S_RDB;
                                end
                                OP_RND: begin
                                    gp_we    = 1'b1;
                                    gp_wdata = r_rnd & op_kk;
                                end
                                OP_MISC: begin
                                    case (op_kk)
                                        FX_DT_RD: begin
                                            gp_we    = 1'b1;
                                            gp_wdata = r_delay;
                                        end
                                        FX_DT_WR, FX_ST_WR, FX_ADDI, FX_GLYPH, FX_BCD: begin
                                            n_state = S_RDB;
                                        end
                                        FX_STORE: begin
                                            n_cnt   = 4'h0;
                                            n_state = S_ST_RD;
                                        end
                                        FX_LOAD: begin
                                            n_cnt   = 4'h0;
                                            n_state = S_LD_RD;
                                        end
                                        default: n_state = S_RDX;
                                    endcase
                                end
                                default: n_state = S_RDX;
                            endcase
                        end
                    end
                    default: n_state = S_RDX;
                endcase
            end

            S_MRD: begin
                n_rd    = mem_rdata;
                n_state = S_RDX;
            end

            S_RDB: begin
                n_a      = gp_rval;
                gp_raddr = op_y;
                n_state  = S_EXEC;
            end

            S_EXEC: begin
                n_state   = S_RDX;
                alu_req.a = {8'h00, r_a};
                alu_req.b = {8'h00, gp_rval};
                case (op_hi)
                    OP_SEK, OP_SNEK: begin
                        alu_req.op = ALU_EQ;
                        alu_req.b  = {8'h00, op_kk};
                        if (alu_rsp.flag == (op_hi == OP_SEK)) begin
                            n_state = S_SKIP;
                        end
                    end
                    OP_SER, OP_SNER: begin
                        alu_req.op = ALU_EQ;
                        if (alu_rsp.flag == (op_hi == OP_SER)) begin
                            n_state = S_SKIP;
                        end
                    end
                    OP_ADDK: begin
                        alu_req.op = ALU_ADD8;
                        alu_req.b  = {8'h00, op_kk};
                        gp_we      = 1'b1;
                        gp_wdata   = alu_rsp.res[7:0];
                    end
                    OP_ALU: begin
                        gp_we    = 1'b1;
                        gp_wdata = alu_rsp.res[7:0];
                        n_flag   = alu_rsp.flag;
                        n_state  = S_WRF;
                        case (op_sub)
                            SUB_LD: begin
                                alu_req.op = ALU_PASS;
                                n_state    = S_RDX;
                            end
                            SUB_OR: begin
                                alu_req.op = ALU_OR;
                                n_state    = S_RDX;
                            end
                            SUB_AND: begin
                                alu_req.op = ALU_AND;
                                n_state    = S_RDX;
                            end
                            SUB_XOR: begin
                                alu_req.op = ALU_XOR;
                                n_state    = S_RDX;
                            end
                            SUB_ADD:  alu_req.op = ALU_ADD8;
                            SUB_SUB:  alu_req.op = ALU_SUB8;
                            SUB_SHR:  alu_req.op = ALU_SHR;
                            SUB_SUBN: alu_req.op = ALU_SUBN8;
                            SUB_SHL:  alu_req.op = ALU_SHL;
                            default: begin
                                gp_we   = 1'b0;
                                n_state = S_RDX;
                            end
                        endcase
                    end
                    OP_JPV0: begin
                        alu_req.op = ALU_ADD12;
                        alu_req.a  = {4'h0, op_nnn};
                        alu_req.b  = {8'h00, r_a};
                        n_pc       = alu_rsp.res[11:0];
                    end
                    OP_MISC: begin
                        case (op_kk)
                            FX_DT_WR: n_delay = r_a;
                            FX_ST_WR: n_sound = r_a;
                            FX_ADDI: begin
                                alu_req.op = ALU_ADD16;
                                alu_req.a  = r_idx;
                                alu_req.b  = {8'h00, r_a};
                                n_idx      = alu_rsp.res;
                            end
                            FX_GLYPH: begin
                                alu_req.op = ALU_MUL;
                                n_idx      = alu_rsp.res;
                            end
                            FX_BCD: begin
                                n_cnt   = 4'h0;
                                n_state = S_BCD_D;
                            end
                            default: n_state = S_RDX;
                        endcase
                    end
                    default: n_state = S_RDX;
                endcase
            end

            S_SKIP: begin
                alu_req.op = ALU_ADD12;
                alu_req.a  = {4'h0, r_pc};
                alu_req.b  = 16'd2;
                n_pc       = alu_rsp.res[11:0];
                n_state    = S_RDX;
            end

            S_WRF: begin
                // flag goes last so that VF wins when x is F
                gp_we    = 1'b1;
                gp_waddr = 4'hF;
                gp_wdata = {7'h00, r_flag};
                n_state  = S_RDX;
            end

            S_BCD_D: begin
                alu_req.a = {8'h00, r_a};
                case (r_cnt)
                    4'h0:    alu_req.op = ALU_DIG_H;
                    4'h1:    alu_req.op = ALU_DIG_T;
                    default: alu_req.op = ALU_DIG_O;
                endcase
                n_tmp   = alu_rsp.res[7:0];
                n_state = S_BCD_W;
            end

            S_BCD_W: begin
                alu_req.op = ALU_ADD16;
                alu_req.a  = r_idx;
                alu_req.b  = {12'h000, r_cnt};
                mem_we     = 1'b1;
                mem_waddr  = mem_index(alu_rsp.res[11:0]);
                mem_wdata  = r_tmp;
                if (r_cnt == 4'd2) begin
                    n_state = S_RDX;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_BCD_D;
                end
            end

            S_ST_RD: begin
                gp_raddr = r_cnt;
                n_state  = S_ST_WR;
            end

            S_ST_WR: begin
                alu_req.op = ALU_ADD16;
                alu_req.a  = r_idx;
                alu_req.b  = {12'h000, r_cnt};
                mem_we     = 1'b1;
                mem_waddr  = mem_index(alu_rsp.res[11:0]);
                mem_wdata  = gp_rval;
                if (r_cnt == op_x) begin
                    n_state = S_RDX;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_ST_RD;
                end
            end

            S_LD_RD: begin
                alu_req.op = ALU_ADD16;
                alu_req.a  = r_idx;
                alu_req.b  = {12'h000, r_cnt};
                mem_raddr  = mem_index(alu_rsp.res[11:0]);
                n_state    = S_LD_WR;
            end

            S_LD_WR: begin
                gp_we    = 1'b1;
                gp_waddr = r_cnt;
                gp_wdata = mem_rdata;
                if (r_cnt == op_x) begin
                    n_state = S_RDX;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_LD_RD;
                end
            end

            S_RDX: begin
                gp_raddr = op_x;
                n_state  = S_RDF;
            end

            S_RDF: begin
                n_dest   = gp_rval;
                gp_raddr = 4'hF;
                n_state  = S_DONE;
            end

            S_DONE: begin
                // hold the VF read until the output register frees up
                gp_raddr = 4'hF;
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_pc    = r_pc;
                    n_o_idx   = r_idx;
                    n_o_dest  = r_dest;
                    n_o_flag  = gp_rval;
                    n_o_delay = r_delay;
                    n_o_sound = r_sound;
                    n_o_rd    = r_rd;
                    n_o_fault = r_fault;
                    n_state   = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_pc       <= 12'h000;
            r_idx      <= 16'h0000;
            r_delay    <= 8'h00;
            r_sound    <= 8'h00;
            r_sp       <= '0;
            r_gp_valid <= 16'h0000;
            r_gp_rv    <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_pc      <= n_pc;
            r_idx     <= n_idx;
            r_delay   <= n_delay;
            r_sound   <= n_sound;
            r_sp      <= n_sp;
            r_o_valid <= n_o_valid;
            if (gp_we) begin
                r_gp_valid[gp_waddr] <= 1'b1;
            end
            r_gp_rv <= r_gp_valid[gp_raddr];
        end
        if (stack_we) begin
            r_stack[r_sp[SP_IW-1:0]] <= r_pc;
        end
        r_func    <= n_func;
        r_op      <= n_op;
        r_rnd     <= n_rnd;
        r_addr    <= n_addr;
        r_data    <= n_data;
        r_cnt     <= n_cnt;
        r_a       <= n_a;
        r_tmp     <= n_tmp;
        r_flag    <= n_flag;
        r_fault   <= n_fault;
        r_rd      <= n_rd;
        r_dest    <= n_dest;
        r_o_pc    <= n_o_pc;
        r_o_idx   <= n_o_idx;
        r_o_dest  <= n_o_dest;
        r_o_flag  <= n_o_flag;
        r_o_delay <= n_o_delay;
        r_o_sound <= n_o_sound;
        r_o_rd    <= n_o_rd;
        r_o_fault <= n_o_fault;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_prog_counter = r_o_pc;
    assign o_index_value  = r_o_idx;
    assign o_dest_value   = r_o_dest;
    assign o_flag_value   = r_o_flag;
    assign o_delay_value  = r_o_delay;
    assign o_sound_value  = r_o_sound;
    assign o_read_data    = r_o_rd;
    assign o_stack_fault  = r_o_fault;

`ifndef SYNTH
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_fault_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stack_fault) |-> (o_read_data == 8'h00))
        else $error("stack fault reported on a memory read result");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_DISPATCH))
        else $error("accepted transfer not dispatched");
`endif

endmodule

@@ rtl/c8ie_ram.sv @@
module c8ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/c8ie_alu.sv @@
module c8ie_alu
    import c8ie_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [7:0] a8;
    logic [7:0] b8;
    logic [8:0] sum9;
    logic [1:0] hund;
    logic [7:0] rem100;
    logic [15:0] tprod;
    logic [3:0] tens;
    logic [7:0] ones;

    always_comb begin
        a8   = i_req.a[7:0];
        b8   = i_req.b[7:0];
        sum9 = {1'b0, a8} + {1'b0, b8};

        // decimal digits of an 8-bit value
        if (a8 >= 8'd200) begin
            hund = 2'd2;
        end else if (a8 >= 8'd100) begin
            hund = 2'd1;
        end else begin
            hund = 2'd0;
        end
        rem100 = a8 - 8'(hund) * 8'd100;
        tprod  = 16'(rem100) * 16'd205;     // x/10 for x < 100
        tens   = tprod[14:11];
        ones   = rem100 - 8'(tens) * 8'd10;

        o_rsp.res  = 16'h0000;
        o_rsp.flag = 1'b0;
        case (i_req.op)
            ALU_PASS:  o_rsp.res = {8'h00, b8};
            ALU_OR:    o_rsp.res = {8'h00, a8 | b8};
            ALU_AND:   o_rsp.res = {8'h00, a8 & b8};
            ALU_XOR:   o_rsp.res = {8'h00, a8 ^ b8};
            ALU_ADD8: begin
                o_rsp.res  = {8'h00, sum9[7:0]};
                o_rsp.flag = sum9[8];
            end
            ALU_SUB8: begin
                o_rsp.res  = {8'h00, a8 - b8};
                o_rsp.flag = a8 > b8;
            end
            ALU_SUBN8: begin
                o_rsp.res  = {8'h00, b8 - a8};
                o_rsp.flag = b8 > a8;
            end
            ALU_SHR: begin
                o_rsp.res  = {8'h00, 1'b0, a8[7:1]};
                o_rsp.flag = a8[0];
            end
            ALU_SHL: begin
                o_rsp.res  = {8'h00, a8[6:0], 1'b0};
                o_rsp.flag = a8[7];
            end
            ALU_EQ:    o_rsp.flag = a8 == b8;
            ALU_ADD12: o_rsp.res = {4'h0, i_req.a[11:0] + i_req.b[11:0]};
            ALU_ADD16: o_rsp.res = i_req.a + i_req.b;
            ALU_MUL:   o_rsp.res = 16'(32'(i_req.a) * 32'(GLYPH_HEIGHT));
            ALU_DIG_H: o_rsp.res = {14'h0000, hund};
            ALU_DIG_T: o_rsp.res = {12'h000, tens};
            ALU_DIG_O: o_rsp.res = {8'h00, ones};
            default:   o_rsp.res = 16'h0000;
        endcase
    end

endmodule

@@ test/tb_chip8_instruction_execute_top.sv @@
`timescale 1ns / 1ps

module tb_chip8_instruction_execute_top;
    import c8ie_pkg::*;

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_func;
    logic [15:0] i_opcode;
    logic [7:0]  i_random_byte;
    logic [11:0] i_mem_addr;
    logic [7:0]  i_mem_data;
    logic        o_valid;
    logic        i_ready;
    logic [11:0] o_prog_counter;
    logic [15:0] o_index_value;
    logic [7:0]  o_dest_value;
    logic [7:0]  o_flag_value;
    logic [7:0]  o_delay_value;
    logic [7:0]  o_sound_value;
    logic [7:0]  o_read_data;
    logic        o_stack_fault;

    chip8_instruction_execute_top DUT (.*);

    // ------------------------------------------------------------------
    // Transfer records
    // ------------------------------------------------------------------
    typedef struct {
        t_func       func;
        logic [15:0] op;
        logic [7:0]  rnd;
        logic [11:0] addr;
        logic [7:0]  data;
    } t_cmd;

    typedef struct {
        logic [11:0] pc;
        logic [15:0] idx;
        logic [7:0]  vx;
        logic [7:0]  vf;
        logic [7:0]  dt;
        logic [7:0]  st;
        logic [7:0]  rd;
        logic        fault;
    } t_state_snap;

    // Directed row: 'known' rows carry a hand-typed pc / read byte / fault
    typedef struct {
        t_cmd        c;
        bit          known;
        logic [11:0] k_pc;
        logic [7:0]  k_rd;
        logic        k_fault;
    } t_row;

    // ------------------------------------------------------------------
    // Interpreter shadow state
    // ------------------------------------------------------------------
    logic [7:0]  sh_v [16];
    logic [15:0] sh_i;
    logic [11:0] sh_pc;
    logic [7:0]  sh_dt;
    logic [7:0]  sh_st;
    logic [11:0] sh_stack [STACK_DEPTH];
    int          sh_sp;
    logic [7:0]  sh_mem [MEM_BYTES];

    t_state_snap pending_q [$];
    int errors = 0;
    int n_sent = 0;
    int n_recv = 0;
    int n_faults = 0;
    bit did_hold = 0;

    initial begin
        for (int k = 0; k < 16; k++) sh_v[k] = 8'h00;
        for (int k = 0; k < STACK_DEPTH; k++) sh_stack[k] = 12'h000;
        for (int k = 0; k < MEM_BYTES; k++) sh_mem[k] = (k < GLYPH_BYTES) ? GLYPHS[k] : 8'h00;
        sh_i  = 16'h0000;
        sh_pc = 12'h000;
        sh_dt = 8'h00;
        sh_st = 8'h00;
        sh_sp = 0;
    end

    // Execute one transfer on the shadow state, return the expected result
    function automatic t_state_snap execute_cmd(t_cmd c);
        t_state_snap r;
        logic [3:0]  x, y;
        logic [7:0]  kk, vx, vy, f;
        logic [8:0]  sum;
        bit          setf;
        x = c.op[11:8];
        y = c.op[7:4];
        kk = c.op[7:0];
        vx = sh_v[x];
        vy = sh_v[y];
        r.fault = 1'b0;
        r.rd = 8'h00;
        case (c.func)
            FN_EXEC: begin
                if (c.op[15:12] == OP_RND) begin
                    sh_v[x] = c.rnd & kk;
                end else if (c.op == OP_RET) begin
                    if (sh_sp == 0) begin
                        r.fault = 1'b1;
                    end else begin
                        sh_sp--;
                        sh_pc = sh_stack[sh_sp];
                    end
                end else begin
                    case (c.op[15:12])
                        OP_JP:   sh_pc = c.op[11:0];
                        OP_CALL: begin
                            if (sh_sp >= STACK_DEPTH) begin
                                r.fault = 1'b1;
                            end else begin
                                sh_stack[sh_sp] = sh_pc;
                                sh_sp++;
                                sh_pc = c.op[11:0];
                            end
                        end
                        OP_SEK:  if (vx == kk) sh_pc = sh_pc + 12'd2;
                        OP_SNEK: if (vx != kk) sh_pc = sh_pc + 12'd2;
                        OP_SER:  if (vx == vy) sh_pc = sh_pc + 12'd2;
                        OP_SNER: if (vx != vy) sh_pc = sh_pc + 12'd2;
                        OP_LDK:  sh_v[x] = kk;
                        OP_ADDK: sh_v[x] = vx + kk;
                        OP_LDI:  sh_i = {4'h0, c.op[11:0]};
                        OP_JPV0: sh_pc = c.op[11:0] + {4'h0, sh_v[0]};
                        OP_ALU: begin
                            setf = 1'b1;
                            f = 8'h00;
                            case (c.op[3:0])
                                SUB_LD:  begin sh_v[x] = vy; setf = 0; end
                                SUB_OR:  begin sh_v[x] = vx | vy; setf = 0; end
                                SUB_AND: begin sh_v[x] = vx & vy; setf = 0; end
                                SUB_XOR: begin sh_v[x] = vx ^ vy; setf = 0; end
                                SUB_ADD: begin
                                    sum = {1'b0, vx} + {1'b0, vy};
                                    sh_v[x] = sum[7:0];
                                    f = {7'd0, sum[8]};
                                end
                                SUB_SUB:  begin sh_v[x] = vx - vy; f = {7'd0, vx > vy}; end
                                SUB_SHR:  begin sh_v[x] = vx >> 1; f = {7'd0, vx[0]}; end
                                SUB_SUBN: begin sh_v[x] = vy - vx; f = {7'd0, vy > vx}; end
                                SUB_SHL:  begin sh_v[x] = vx << 1; f = {7'd0, vx[7]}; end
                                default: setf = 0;
                            endcase
                            // flag lands after Vx, so VF as destination keeps the flag
                            if (setf) sh_v[15] = f;
                        end
                        OP_MISC: begin
                            case (kk)
                                FX_DT_RD: sh_v[x] = sh_dt;
                                FX_DT_WR: sh_dt = vx;
                                FX_ST_WR: sh_st = vx;
                                FX_ADDI:  sh_i = sh_i + {8'h00, vx};
                                FX_GLYPH: sh_i = {8'h00, vx} * 16'(GLYPH_HEIGHT);
                                FX_BCD: begin
                                    sh_mem[sh_i[11:0]]         = vx / 100;
                                    sh_mem[sh_i[11:0] + 12'd1] = (vx / 10) % 10;
                                    sh_mem[sh_i[11:0] + 12'd2] = vx % 10;
                                end
                                FX_STORE:
                                    for (int k = 0; k <= x; k++)
                                        sh_mem[sh_i[11:0] + 12'(k)] = sh_v[k];
                                FX_LOAD:
                                    for (int k = 0; k <= x; k++)
                                        sh_v[k] = sh_mem[sh_i[11:0] + 12'(k)];
                                default: ;
                            endcase
                        end
                        default: ;  // 0nnn, Dxyn and friends: no effect
                    endcase
                end
            end
            FN_WRITE: sh_mem[c.addr] = c.data;
            FN_READ:  r.rd = sh_mem[c.addr];
            default:  sh_pc = 12'(LOAD_ADDRESS);
        endcase
        r.pc  = sh_pc;
        r.idx = sh_i;
        r.vx  = sh_v[x];
        r.vf  = sh_v[15];
        r.dt  = sh_dt;
        r.st  = sh_st;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch at result %0d: %s got %0h want %0h", n_recv, field, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Random stimulus helpers
    // ------------------------------------------------------------------
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_cmd rand_cmd(int n);
        t_cmd c;
        int r;
        logic [7:0] fx_list [8];
        logic [3:0] alu_list [9];
        fx_list  = '{FX_DT_RD, FX_DT_WR, FX_ST_WR, FX_ADDI, FX_GLYPH, FX_BCD, FX_STORE, FX_LOAD};
        alu_list = '{SUB_LD, SUB_OR, SUB_AND, SUB_XOR, SUB_ADD, SUB_SUB, SUB_SHR,
                     SUB_SUBN, SUB_SHL};
        c.op   = 16'($urandom);
        c.rnd  = 8'($urandom);
        c.addr = 12'($urandom);
        c.data = 8'($urandom);
        c.func = FN_EXEC;
        // call storm then return storm: overflows and drains the stack
        if (n >= 400 && n < 420) begin
            c.op[15:12] = OP_CALL;
            return c;
        end
        if (n >= 420 && n < 440) begin
            c.op = OP_RET;
            return c;
        end
        r = $urandom_range(0, 99);
        if (r < 10) c.func = FN_WRITE;
        else if (r < 18) c.func = FN_READ;
        else if (r < 21) c.func = FN_START;
        else begin
            case (c.op[15:12])
                OP_SYS: begin
                    r = $urandom_range(0, 3);
                    if (r < 2) c.op = OP_RET;
                    else if (r == 2) c.op = 16'h00E0;
                end
                OP_ALU:  if ($urandom_range(0, 9) < 8) c.op[3:0] = alu_list[$urandom_range(0, 8)];
                OP_MISC: if ($urandom_range(0, 9) < 9) c.op[7:0] = fx_list[$urandom_range(0, 7)];
                default: ;
            endcase
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_cmd(t_cmd c, bit known, logic [11:0] k_pc, logic [7:0] k_rd,
                            logic k_fault);
        t_state_snap e;
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= c.func;
        i_opcode      <= c.op;
        i_random_byte <= c.rnd;
        i_mem_addr    <= c.addr;
        i_mem_data    <= c.data;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        e = execute_cmd(c);
        if (known) begin
            e.pc    = k_pc;
            e.rd    = k_rd;
            e.fault = k_fault;
        end
        pending_q.push_back(e);
        n_sent++;
    endtask

    t_row rows [$];

    function automatic t_row mk(t_func f, logic [15:0] op, logic [11:0] a, logic [7:0] d,
                                logic [7:0] rnd = 8'hFF, bit known = 0,
                                logic [11:0] kp = 0, logic [7:0] kr = 0, logic kf = 0);
        t_row r;
        r.c.func = f; r.c.op = op; r.c.rnd = rnd; r.c.addr = a; r.c.data = d;
        r.known = known; r.k_pc = kp; r.k_rd = kr; r.k_fault = kf;
        return r;
    endfunction

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_func        <= FN_EXEC;
        i_opcode      <= 16'h0000;
        i_random_byte <= 8'h00;
        i_mem_addr    <= 12'h000;
        i_mem_data    <= 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // typed rows straight after reset: font image, empty-stack return, program start
        rows.push_back(mk(FN_READ,  16'h0000, 12'h000, 8'h00, 8'h00, 1, 12'h000, 8'hF0, 0));
        rows.push_back(mk(FN_READ,  16'hF000, 12'd79,  8'h00, 8'h00, 1, 12'h000, 8'h80, 0));
        rows.push_back(mk(FN_READ,  16'h0000, 12'hFFF, 8'h00, 8'h00, 1, 12'h000, 8'h00, 0));
        rows.push_back(mk(FN_EXEC,  OP_RET,   12'h000, 8'h00, 8'h00, 1, 12'h000, 8'h00, 1));
        rows.push_back(mk(FN_START, 16'h0000, 12'h000, 8'h00, 8'h00, 1, 12'd512,  8'h00, 0));
        // predicted rows: extremes, flag ops, VF as destination, wraps
        rows.push_back(mk(FN_WRITE, 16'hFFFF, 12'hFFF, 8'hFF));
        rows.push_back(mk(FN_EXEC,  16'h60FF, 12'h000, 8'h00));
        rows.push_back(mk(FN_EXEC,  16'h61FF, 12'h000, 8'h00));
        rows.push_back(mk(FN_EXEC,  16'h8014, 12'h000, 8'h00));
        rows.push_back(mk(FN_EXEC,  16'h8015, 12'h000, 8'h00));
        rows.push_back(mk(FN_EXEC,  16'h8017, 12'h000, 8'h00));
        rows.push_back(mk(FN_EXEC,  16'h8116, 12'h000, 8'h00));
        rows.push_back(mk(FN_EXEC,  16'h811E, 12'h000, 8'h00));
        rows.push_back(mk(FN_EXEC,  16'h6F81, 12'h000, 8'h00));
        rows.push_back(mk(FN_EXEC,  16'h8FFE, 12'h000, 8'h00));
        rows.push_back(mk(FN_EXEC,  16'hC2FF, 12'h000, 8'h00, 8'hA5));
        rows.push_back(mk(FN_EXEC,  16'hAFFE, 12'h000, 8'h00));
        rows.push_back(mk(FN_EXEC,  16'hF233, 12'h000, 8'h00));
        rows.push_back(mk(FN_EXEC,  16'hFF55, 12'h000, 8'h00));
        rows.push_back(mk(FN_EXEC,  16'hFF65, 12'h000, 8'h00));
        rows.push_back(mk(FN_EXEC,  16'hBFFF, 12'h000, 8'h00));
        rows.push_back(mk(FN_EXEC,  16'h2FFF, 12'h000, 8'h00));
        rows.push_back(mk(FN_EXEC,  16'hD123, 12'h000, 8'h00));
        rows.push_back(mk(FN_EXEC,  16'h00E0, 12'h000, 8'h00));
        rows.push_back(mk(FN_EXEC,  OP_RET,   12'h000, 8'h00));

        foreach (rows[k])
            send_cmd(rows[k].c, rows[k].known, rows[k].k_pc, rows[k].k_rd, rows[k].k_fault);

        for (int n = 0; n < 1700; n++) begin
            // one full drain mid-run: sender waits for every outstanding result
            if (n == 900) begin
                i_valid <= 1'b0;
                while (pending_q.size() != 0) @(posedge i_clk);
            end
            send_cmd(rand_cmd(n), 0, 0, 0, 0);
        end
        i_valid <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("covered %0d transfers (%0d stack faults), all opcode classes and services,",
                 n_sent, n_faults);
        $display("with random idling, one long output stall and one full drain");
        if (errors == 0) begin
            $display("[chip8_instruction_execute_top] OK");
        end else begin
            $display("[chip8_instruction_execute_top] ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------
    initial begin
        t_state_snap e;
        int stall_left;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (pending_q.size() == 0) begin
                    report_mismatch("unexpected transfer", 1, 0);
                end else begin
                    e = pending_q.pop_front();
                    if (o_prog_counter != e.pc)  report_mismatch("pc", o_prog_counter, e.pc);
                    if (o_index_value != e.idx)  report_mismatch("I", o_index_value, e.idx);
                    if (o_dest_value != e.vx)    report_mismatch("Vx", o_dest_value, e.vx);
                    if (o_flag_value != e.vf)    report_mismatch("VF", o_flag_value, e.vf);
                    if (o_delay_value != e.dt)   report_mismatch("DT", o_delay_value, e.dt);
                    if (o_sound_value != e.st)   report_mismatch("ST", o_sound_value, e.st);
                    if (o_read_data != e.rd)     report_mismatch("read", o_read_data, e.rd);
                    if (o_stack_fault != e.fault)
                        report_mismatch("fault", o_stack_fault, e.fault);
                    if (e.fault) n_faults++;
                end
                n_recv++;
            end
            // long hold-off while the sender keeps offering: input must back up
            if (!did_hold && n_recv == 150) begin
                did_hold = 1;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 75) begin
                i_ready <= 1'b1;
            end else begin
                stall_left = gap_len();
                i_ready <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no transfer on either channel
    // ------------------------------------------------------------------
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 20000) begin
            $display("[chip8_instruction_execute_top] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
